// File: hdl/assert_macros.svh
// Assertion macros for the shortest path block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

// File: hdl/dspc_pkg.sv
package dspc_pkg;
  localparam int MAX_NODES  = 256;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int PORT_NODE_W = 9;
  localparam int WEIGHT_W   = 20;
  localparam int COST_W     = 30;
  localparam int CNT_W      = NODE_W + 1;
  localparam logic [COST_W-1:0] INF_COST = COST_W'(100000000);
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef struct packed {
    logic [PORT_NODE_W-1:0] row_node;
    logic [PORT_NODE_W-1:0] col_node;
    logic [WEIGHT_W-1:0]    edge_weight;
    logic                   last_entry;
  } in_item_t;

  function automatic logic [COST_W-1:0] sat_add(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction
endpackage

// File: hdl/dspc_if.sv
interface dspc_in_if import dspc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dspc_out_if import dspc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] best_cost;
  modport source (output valid, output best_cost, input ready);
  modport sink (input valid, input best_cost, output ready);
endinterface

// File: hdl/dense_shortest_path_with_cycles.sv
// dense_shortest_path_with_cycles
// Input channel (in): one weight matrix entry per transaction (row_node,
// col_node, edge_weight, last_entry). Entries with both nodes in 1..256 go
// into the weight store (others are dropped), so the matrix loads at one
// transaction per cycle while idle. An entry with last_entry set is handled
// so too and then starts two FIFO label-correcting searches, from node 1 and
// from node n, through one shared add/compare unit. Each run starts with a
// sweep over the n nodes that sets the distances to infinity (the source to
// zero), clears the queued flags and seeds the queue. A dequeue passes
// through S_NEXT, S_UWT and S_DEQ, then for each column re-reads the
// dequeued distance, reads column distance and weight and updates; in_ready
// stays low throughout. The result is registered at the end of the second run.
// Output channel (out): one transaction with best_cost per last entry;
// it is held in an output register until out_ready, and the next matrix
// entry may be accepted while it waits, but a new last entry waits.
// cfg_we/cfg_wdata write node_count; write only while idle.
// Reset (rst_n low, synchronous): node_count=2, queue empty.
// The weight store is not cleared; entries never written read as anything.
module dense_shortest_path_with_cycles
  import dspc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [PORT_NODE_W-1:0] cfg_wdata,
  dspc_in_if.sink                in_ch,
  dspc_out_if.source             out_ch
);
`include "assert_macros.svh"

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLR   = 4'd1;
  localparam logic [3:0] S_DEQ   = 4'd2;
  localparam logic [3:0] S_RD    = 4'd3;
  localparam logic [3:0] S_UPD   = 4'd4;
  localparam logic [3:0] S_NEXT  = 4'd5;
  localparam logic [3:0] S_DONE  = 4'd6;
  localparam logic [3:0] S_URD   = 4'd7;
  localparam logic [3:0] S_UWT   = 4'd8;

  logic [3:0] state_r;
  logic [PORT_NODE_W-1:0] node_count_r;
  logic [CNT_W-1:0] n_use;
  logic pass_r;                        // 0: run from node 1, 1: from node n
  logic [NODE_W-1:0] src_r, u_r, v_r;
  logic [CNT_W-1:0] qcnt_r;
  logic [NODE_W-1:0] head_r, tail_r;
  logic [COST_W-1:0] du_r, cyc_r, first_cyc_r, path_r;
  logic [COST_W-1:0] dist_n1_r;
  logic out_valid_r;
  logic [COST_W-1:0] out_cost_r;

  always_comb begin
    if (node_count_r == '0) n_use = CNT_W'(1);
    else if (node_count_r > PORT_NODE_W'(MAX_NODES)) n_use = CNT_W'(MAX_NODES);
    else n_use = CNT_W'(node_count_r);
  end

  // Weight memory: written from the input, read during relaxation.
  logic w_we;
  logic [2*NODE_W-1:0] w_waddr, w_raddr;
  logic [WEIGHT_W-1:0] w_rdata;
  logic in_ok;
  assign in_ok = in_ch.data.row_node >= PORT_NODE_W'(1)
              && in_ch.data.row_node <= PORT_NODE_W'(MAX_NODES)
              && in_ch.data.col_node >= PORT_NODE_W'(1)
              && in_ch.data.col_node <= PORT_NODE_W'(MAX_NODES);
  logic in_fire;
  logic in_ready_w;
  assign in_ready_w = (state_r == S_IDLE) && !(out_valid_r && in_ch.data.last_entry);
  assign in_ch.ready = in_ready_w;
  assign in_fire = in_ch.valid && in_ready_w;
  assign w_we = in_fire && in_ok;
  assign w_waddr = {NODE_W'(in_ch.data.row_node - 1'b1), NODE_W'(in_ch.data.col_node - 1'b1)};
  assign w_raddr = {u_r, v_r};
  dspc_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_NODES*MAX_NODES)) u_wram (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(in_ch.data.edge_weight),
    .raddr(w_raddr), .rdata(w_rdata));

  // Distance memory.
  logic d_we;
  logic [NODE_W-1:0] d_waddr, d_raddr;
  logic [COST_W-1:0] d_wdata, d_rdata;
  dspc_ram #(.WIDTH(COST_W), .DEPTH(MAX_NODES)) u_dram (
    .clk, .we(d_we), .waddr(d_waddr), .wdata(d_wdata), .raddr(d_raddr), .rdata(d_rdata));

  // Work queue memory.
  logic q_we;
  logic [NODE_W-1:0] q_wdata, q_rdata;
  dspc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_qram (
    .clk, .we(q_we), .waddr(tail_r), .wdata(q_wdata), .raddr(head_r), .rdata(q_rdata));

  // Queued flag memory: read for column v, set on push, cleared by the sweep and on dequeue.
  logic f_we;
  logic [NODE_W-1:0] f_waddr;
  logic f_wdata, f_rdata;
  dspc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_fram (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(v_r), .rdata(f_rdata));

  // Shared add/compare unit.
  logic [COST_W-1:0] cand;
  logic improve;
  assign cand = sat_add(du_r, COST_W'(w_rdata));
  assign improve = d_rdata > cand;

  logic push;
  assign push = (state_r == S_UPD) && improve && !f_rdata
             && qcnt_r < CNT_W'(MAX_NODES);
  logic v_last;
  assign v_last = CNT_W'(v_r) == n_use - 1'b1;

  always_comb begin
    d_we = 1'b0;
    d_waddr = v_r;
    d_wdata = INF_COST;
    d_raddr = v_r;
    q_we = 1'b0;
    q_wdata = v_r;
    f_we = 1'b0;
    f_waddr = v_r;
    f_wdata = 1'b0;
    case (state_r)
      S_CLR: begin
        d_we = 1'b1;
        d_wdata = (v_r == src_r) ? '0 : INF_COST;
        q_we = v_last;
        q_wdata = src_r;
        f_we = 1'b1;
      end
      S_DEQ: begin
        d_raddr = q_rdata;
        f_we = 1'b1;
        f_waddr = q_rdata;
      end
      S_URD: d_raddr = u_r;
      S_UPD: begin
        d_we = improve;
        d_wdata = cand;
        q_we = push;
        f_we = push;
        f_wdata = 1'b1;
      end
      default: ;
    endcase
  end

  logic [COST_W-1:0] pair;
  assign pair = sat_add(first_cyc_r, cyc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      node_count_r <= PORT_NODE_W'(2);
      qcnt_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      out_valid_r <= 1'b0;
      pass_r <= 1'b0;
      cyc_r <= INF_COST;
      first_cyc_r <= INF_COST;
      path_r <= INF_COST;
    end else begin
      if (cfg_we) node_count_r <= cfg_wdata;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_fire && in_ch.data.last_entry) begin
          pass_r <= 1'b0;
          src_r <= '0;
          v_r <= '0;
          cyc_r <= INF_COST;
          state_r <= S_CLR;
        end
        S_CLR: begin
          // Sweep the distance store, then seed the queue with the source.
          if (v_last) begin
            tail_r <= tail_r + 1'b1;
            qcnt_r <= CNT_W'(1);
            state_r <= S_NEXT;
          end
          v_r <= v_r + 1'b1;
        end
        S_NEXT: begin
          // Queue read of head is in flight (head address registered).
          if (qcnt_r == '0) begin
            // Hold the distance of node n from the first run.
            if (!pass_r) path_r <= dist_n1_r;
            state_r <= S_DONE;
          end else begin
            state_r <= S_UWT;
          end
        end
        S_UWT: state_r <= S_DEQ;
        S_DEQ: begin
          u_r <= q_rdata;
          head_r <= head_r + 1'b1;
          qcnt_r <= qcnt_r - 1'b1;
          v_r <= '0;
          state_r <= S_URD;
        end
        S_URD: state_r <= S_RD;
        S_RD: begin
          du_r <= d_rdata;
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (v_r == src_r && u_r != v_r && cand < cyc_r) cyc_r <= cand;
          if (push) begin
            tail_r <= tail_r + 1'b1;
            qcnt_r <= qcnt_r + 1'b1;
          end
          v_r <= v_r + 1'b1;
          // Advance: re-read dist[u], then dist[v+1] with its weight; after the last column, go to S_NEXT.
          state_r <= v_last ? S_NEXT : S_URD;
        end
        S_DONE: begin
          if (!pass_r) begin
            // Start the second run from node n.
            pass_r <= 1'b1;
            first_cyc_r <= cyc_r;
            v_r <= '0;
            src_r <= NODE_W'(n_use - 1'b1);
            cyc_r <= INF_COST;
            state_r <= S_CLR;
          end else begin
            out_valid_r <= 1'b1;
            out_cost_r <= (path_r < pair) ? path_r : pair;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Track distance of node index n-1 on every pass 0 write so pass 0 result is known.
  always_ff @(posedge clk) begin
    if (d_we && CNT_W'(d_waddr) == n_use - 1'b1 && !pass_r) dist_n1_r <= d_wdata;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.best_cost = out_cost_r;

  `ASSERT_NEVER(a_busy_not_ready, clk, rst_n, (state_r != S_IDLE) && in_ch.ready,
    "input ready while search runs")
  `ASSERT_IMPL(a_qcnt_bound, clk, rst_n, qcnt_r <= CNT_W'(MAX_NODES), "queue count overflow")
  `ASSERT_IMPL(a_out_hold, clk, rst_n, (out_valid_r && !out_ch.ready) |=> out_valid_r,
    "result dropped while stalled")
endmodule

// File: hdl/dspc_ram.sv
module dspc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: verif/dense_shortest_path_with_cycles_tb.sv
module dense_shortest_path_with_cycles_tb;
  import dspc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 600;

  // Idle profiles: sender light / receiver heavy, swapped, then none.
  typedef enum logic [1:0] {IDLE_SEND_LIGHT, IDLE_RECV_LIGHT, IDLE_NONE} idle_mode_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [PORT_NODE_W-1:0] cfg_wdata;

  dspc_in_if in_if ();
  dspc_out_if out_if ();

  dense_shortest_path_with_cycles dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_if),
    .out_ch(out_if)
  );

  // Matrix entries waiting to be offered, and best costs still owed.
  in_item_t entry_q[$];
  logic [COST_W-1:0] best_cost_q[$];

  // Shadow copy of the block's state.
  logic [WEIGHT_W-1:0] weight_mem[MAX_NODES*MAX_NODES];
  logic [COST_W-1:0] dist_mem[MAX_NODES];
  logic [PORT_NODE_W-1:0] node_count_sh;

  idle_mode_t idle_mode;
  int errors;
  int cycles;
  int sent;
  bit took;
  bit hold_done;
  int hold_left;

  function automatic logic [COST_W-1:0] add_sat(logic [COST_W-1:0] a, logic [COST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
  endfunction

  // FIFO label-correcting search from src; returns cheapest return to src.
  function automatic logic [COST_W-1:0] relax_from(int src, int n);
    logic [COST_W-1:0] cyc;
    logic [COST_W-1:0] cand;
    bit on_queue[MAX_NODES];
    int work[$];
    int u;
    cyc = INF_COST;
    for (int i = 0; i < MAX_NODES; i++) begin
      dist_mem[i] = INF_COST;
      on_queue[i] = 1'b0;
    end
    dist_mem[src] = '0;
    work.push_back(src);
    while (work.size() > 0) begin
      u = work.pop_front();
      on_queue[u] = 1'b0;
      for (int v = 0; v < n; v++) begin
        cand = add_sat(dist_mem[u], COST_W'(weight_mem[u*MAX_NODES+v]));
        if (v == src && u != v && cand < cyc) cyc = cand;
        if (dist_mem[v] > cand) begin
          dist_mem[v] = cand;
          if (!on_queue[v] && work.size() < MAX_NODES) begin
            on_queue[v] = 1'b1;
            work.push_back(v);
          end
        end
      end
    end
    return cyc;
  endfunction

  // Store the entry; on a last entry run both searches and owe one result.
  function automatic void predict_entry(in_item_t e);
    int n;
    logic [COST_W-1:0] path, first_cyc, second_cyc, pair;
    if (e.row_node >= 1 && e.row_node <= MAX_NODES && e.col_node >= 1 && e.col_node <= MAX_NODES)
      weight_mem[(e.row_node-1)*MAX_NODES + (e.col_node-1)] = e.edge_weight;
    if (!e.last_entry) return;
    n = node_count_sh;
    if (n < 1) n = 1;
    if (n > MAX_NODES) n = MAX_NODES;
    first_cyc = relax_from(0, n);
    path = dist_mem[n-1];
    second_cyc = relax_from(n-1, n);
    pair = add_sat(first_cyc, second_cyc);
    best_cost_q.push_back(path < pair ? path : pair);
  endfunction

  task automatic report_mismatch(string what, logic [COST_W-1:0] got, logic [COST_W-1:0] want);
    $display("MISMATCH %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic in_item_t make_entry(int row, int col, int w, bit last);
    in_item_t e;
    e.row_node = PORT_NODE_W'(row);
    e.col_node = PORT_NODE_W'(col);
    e.edge_weight = WEIGHT_W'(w);
    e.last_entry = last;
    return e;
  endfunction

  function automatic int pick_weight();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 15);
      1: return 0;
      2: return 1048575;
      3: return $urandom_range(0, 1000);
      default: return $urandom_range(0, 1048575);
    endcase
  endfunction

  // Fill every row/column in 1..n so no search ever reads a stale entry.
  task automatic load_matrix(int n, bit uniform, int w);
    for (int r = 1; r <= n; r++)
      for (int c = 1; c <= n; c++)
        entry_q.push_back(make_entry(r, c, uniform ? w : pick_weight(), 1'b0));
  endtask

  // Hold until every entry went in and every result came out, then settle.
  task automatic drain();
    wait (entry_q.size() == 0 && best_cost_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_node_count(logic [PORT_NODE_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    node_count_sh = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout at cycle %0d", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  // Input side: accept at the rising edge, predict right away.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      predict_entry(entry_q.pop_front());
      took = 1'b1;
      sent++;
    end
  end

  // Driver: offer the oldest pending entry; keep it up until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !took) begin
      in_if.valid <= 1'b1;
    end else if (entry_q.size() > 0 &&
                 !(idle_mode == IDLE_SEND_LIGHT && $urandom_range(0, 99) < 9) &&
                 !(idle_mode == IDLE_RECV_LIGHT && $urandom_range(0, 99) < 57)) begin
      in_if.valid <= 1'b1;
      in_if.data <= entry_q[0];
    end else begin
      in_if.valid <= 1'b0;
    end
    took = 1'b0;
  end

  // Long receiver hold-off, once, while entries keep coming.
  always @(negedge clk) begin
    if (!hold_done && hold_left == 0 && sent > 300 && best_cost_q.size() > 0) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver ready, stalled per the current profile or the hold-off.
  always @(negedge clk) begin
    if (hold_left > 0)
      out_if.ready <= 1'b0;
    else if (idle_mode == IDLE_SEND_LIGHT)
      out_if.ready <= ($urandom_range(0, 99) >= 57);
    else if (idle_mode == IDLE_RECV_LIGHT)
      out_if.ready <= ($urandom_range(0, 99) >= 9);
    else
      out_if.ready <= 1'b1;
  end

  // Monitor: compare each result transaction with the oldest owed cost.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (best_cost_q.size() == 0) begin
        report_mismatch("unexpected result", out_if.best_cost, '0);
      end else begin
        logic [COST_W-1:0] want;
        want = best_cost_q.pop_front();
        if (out_if.best_cost !== want) report_mismatch("best_cost", out_if.best_cost, want);
      end
    end
  end

  initial begin
    int sizes[12];
    int n, r, c;
    sizes = '{3, 1, 5, 8, 4, 2, 10, 7, 6, 12, 3, 8};
    errors = 0;
    cycles = 0;
    sent = 0;
    took = 1'b0;
    hold_done = 1'b0;
    hold_left = 0;
    idle_mode = IDLE_SEND_LIGHT;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    node_count_sh = 2;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset node count of 2, weight extremes, out-of-range nodes.
    entry_q.push_back(make_entry(1, 1, 0, 1'b0));
    entry_q.push_back(make_entry(1, 2, 1048575, 1'b0));
    entry_q.push_back(make_entry(2, 1, 0, 1'b0));
    entry_q.push_back(make_entry(2, 2, 1048575, 1'b1));
    entry_q.push_back(make_entry(1, 2, 7, 1'b0));
    entry_q.push_back(make_entry(2, 1, 3, 1'b1));
    entry_q.push_back(make_entry(0, 1, 1048575, 1'b1));
    entry_q.push_back(make_entry(1, 0, 0, 1'b0));
    entry_q.push_back(make_entry(511, 2, 5, 1'b1));
    entry_q.push_back(make_entry(2, 257, 5, 1'b1));
    entry_q.push_back(make_entry(256, 256, 1048575, 1'b0));
    entry_q.push_back(make_entry(256, 1, 0, 1'b0));
    entry_q.push_back(make_entry(1, 256, 12345, 1'b0));
    entry_q.push_back(make_entry(2, 1, 1048575, 1'b1));
    drain();

    // Node count of zero acts as a single node: result is distance 0.
    write_node_count(0);
    entry_q.push_back(make_entry(1, 1, 99, 1'b1));
    entry_q.push_back(make_entry(1, 1, 0, 1'b1));
    drain();

    // Random phases over several sizes and idle profiles.
    for (int p = 0; p < 12; p++) begin
      idle_mode = (p < 4) ? IDLE_SEND_LIGHT : (p < 8) ? IDLE_RECV_LIGHT : IDLE_NONE;
      n = sizes[p];
      write_node_count(PORT_NODE_W'(n));
      load_matrix(n, 1'b0, 0);
      for (int k = 0; k < 29; k++) begin
        r = $urandom_range(1, n);
        c = $urandom_range(1, n);
        // Mostly in-range edits, some stray or out-of-range entries.
        case ($urandom_range(0, 9))
          0: r = $urandom_range(0, 511);
          1: c = $urandom_range(0, 511);
          2: begin r = $urandom_range(1, 256); c = $urandom_range(1, 256); end
          default: ;
        endcase
        entry_q.push_back(make_entry(r, c, pick_weight(), ($urandom_range(0, 5) == 0)));
      end
      entry_q.push_back(make_entry(1, 1, pick_weight(), 1'b1));
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
